[sv/ins_pkg.sv]
// ins_pkg: shared widths and constants for the integer Newton square root.
// No dependencies.
`timescale 1ns / 1ps

package ins_pkg;

   localparam int OPERAND_W = 32;
   localparam int ROOT_W    = 19;
   localparam int REM_W     = ROOT_W + 1;
   localparam int QBITS     = 4;
   localparam int DIV_ST    = OPERAND_W / QBITS;

   localparam logic [OPERAND_W-1:0] THRESH_HI  = 32'd268435456;
   localparam logic [OPERAND_W-1:0] THRESH_MID = 32'd1048576;
   localparam logic [OPERAND_W-1:0] THRESH_LO  = 32'd4096;
   localparam int SHIFT_HI  = 14;
   localparam int SHIFT_MID = 10;
   localparam int SHIFT_LO  = 6;
   localparam int SHIFT_MIN = 1;
   localparam logic [ROOT_W-1:0] ROOT_MAX = 19'd262145;

endpackage

[sv/integer_newton_sqrt.sv]
// integer_newton_sqrt: approximate integer square root, fixed Newton steps.
// Depends on ins_pkg.
//
// Usage: drive req_operand and raise start; the item is taken at any edge
// where start is high and busy is low. busy is always low: one item can enter
// every clock cycle.
// The operand gets a start guess, then NEWTON_STEPS steps each of a pipelined
// restoring divider (4 quotient bits per stage, 8 stages) and one averaging
// stage; throughput is one item per cycle.
// Each result shows for one cycle on rsp_root with rsp_valid high. The
// receiver cannot stall, so nothing is held back.
// Reset clears all valid bits; items in flight are dropped. Operands that are
// zero or negative give a root of zero.
`timescale 1ns / 1ps

module integer_newton_sqrt
   import ins_pkg::*;
#(
   parameter int NEWTON_STEPS = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic signed [31:0]   req_operand,
   output logic                 rsp_valid,
   output logic [ROOT_W-1:0]    rsp_root
);

   localparam int NP = NEWTON_STEPS * (DIV_ST + 1);

   logic                 v_ff [0:NP];
   logic                 z_ff [0:NP];
   logic [OPERAND_W-1:0] a_ff [0:NP];
   logic [ROOT_W-1:0]    g_ff [0:NP];
   logic [REM_W-1:0]     r_ff [0:NP];
   logic [OPERAND_W-1:0] q_ff [0:NP];

   logic [OPERAND_W-1:0] a_in;
   logic [OPERAND_W-1:0] g0_in;
   logic                 z_in;

   assign busy = 1'b0;

   always_comb begin
      a_in = {1'b0, req_operand[30:0]};
      z_in = req_operand[31] || (req_operand == 32'sd0);
      if (a_in > THRESH_HI) begin
         g0_in = (a_in >> SHIFT_HI) + 32'd1;
      end else if (a_in > THRESH_MID) begin
         g0_in = (a_in >> SHIFT_MID) + 32'd1;
      end else if (a_in > THRESH_LO) begin
         g0_in = (a_in >> SHIFT_LO) + 32'd1;
      end else begin
         g0_in = (a_in >> SHIFT_MIN) + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else begin
         v_ff[0] <= start && !busy;
      end
      z_ff[0] <= z_in;
      a_ff[0] <= a_in;
      g_ff[0] <= g0_in[ROOT_W-1:0];
      r_ff[0] <= '0;
      q_ff[0] <= '0;
   end

   for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_step
      for (genvar j = 0; j < DIV_ST; j++) begin : g_div
         localparam int P = k * (DIV_ST + 1) + j;
         logic [REM_W-1:0]     rem_in;
         logic [OPERAND_W-1:0] quo_in;

         always_comb begin
            logic [REM_W-1:0] t;
            rem_in = r_ff[P];
            quo_in = q_ff[P];
            for (int i = 0; i < QBITS; i++) begin
               t = {rem_in[REM_W-2:0], a_ff[P][OPERAND_W-1 - j*QBITS - i]};
               if (t >= {1'b0, g_ff[P]}) begin
                  rem_in = t - {1'b0, g_ff[P]};
                  quo_in = {quo_in[OPERAND_W-2:0], 1'b1};
               end else begin
                  rem_in = t;
                  quo_in = {quo_in[OPERAND_W-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               v_ff[P+1] <= 1'b0;
            end else begin
               v_ff[P+1] <= v_ff[P];
            end
            z_ff[P+1] <= z_ff[P];
            a_ff[P+1] <= a_ff[P];
            g_ff[P+1] <= g_ff[P];
            r_ff[P+1] <= rem_in;
            q_ff[P+1] <= quo_in;
         end
      end

      localparam int PA = k * (DIV_ST + 1) + DIV_ST;
      logic [OPERAND_W:0] sum_in;

      assign sum_in = {1'b0, q_ff[PA]} + {{(OPERAND_W + 1 - ROOT_W){1'b0}}, g_ff[PA]};

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[PA+1] <= 1'b0;
         end else begin
            v_ff[PA+1] <= v_ff[PA];
         end
         z_ff[PA+1] <= z_ff[PA];
         a_ff[PA+1] <= a_ff[PA];
         g_ff[PA+1] <= sum_in[ROOT_W:1];
         r_ff[PA+1] <= '0;
         q_ff[PA+1] <= '0;
      end
   end

   assign rsp_valid = v_ff[NP];
   assign rsp_root  = z_ff[NP] ? '0 : g_ff[NP];

   a_latency: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v_ff[0], NP))
      else $error("result without a matching item");

   a_root_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_root <= ROOT_MAX))
      else $error("root above range");

   a_root_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !z_ff[NP]) |-> (rsp_root != '0))
      else $error("zero root for positive operand");

   a_first_divisor: assert property (@(posedge clock) disable iff (reset)
      v_ff[0] |-> (g_ff[0] != '0))
      else $error("zero start guess");

endmodule
